@@ src/assert_macros.svh @@
// assertion macros shared by the skinning blend modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked property, disabled while reset is asserted
`define VSB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// checked property, also checked during reset
`define VSB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

@@ src/vsb_pkg.sv @@
// shared types, constants and arithmetic helpers for the skinning blend block
package vsb_pkg;

    localparam int MAX_BONES   = 128;
    localparam int BONE_W      = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
    localparam int BANK_AW     = BONE_W + 2;
    localparam int BANK_DEPTH  = 1 << BANK_AW;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic       OP_WRITE = 1'b0;
    localparam logic       OP_APPLY = 1'b1;
    localparam logic [1:0] ROW_LAST = 2'd3;

    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_APPLY,
        CMD_FLUSH
    } t_cmd_kind;

    // classified item passed from front to back
    typedef struct packed {
        t_cmd_kind          kind;
        logic               last;
        logic [BONE_W-1:0]  bone;
        logic [3:0]         elem;
        logic signed [31:0] value;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [17:0] weight;
    } t_cmd;

    // control tag that travels with each matrix row through the datapath
    typedef struct packed {
        logic       valid;
        logic [1:0] row;
        logic       apply;
        logic       emit;
    } t_tag;

    // clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] res;
        if (v > 66'sh0_7FFF_FFFF) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < -66'sh0_8000_0000) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

@@ src/vsb_ram.sv @@
// generic single write port, single read port ram with registered read
module vsb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/vsb_front.sv @@
// front end: accepts items, classifies them and queues work for the back end
`include "assert_macros.svh"

module vsb_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_opcode,
    input  logic [7:0]         i_bone_index,
    input  logic [3:0]         i_element_index,
    input  logic signed [31:0] i_element_value,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [17:0] i_weight,
    input  logic               i_last_influence,
    output vsb_pkg::t_cmd      o_cmd,
    output logic               o_cmd_valid,
    input  logic               i_cmd_pop
);
    import vsb_pkg::*;

    logic [7:0]        r_bone_count;
    t_cmd              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;

    logic in_range;
    logic contributes;
    logic keep;
    logic push;
    t_cmd cmd;

    // bone count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bone_count <= '0;
        end else if (i_cfg_we) begin
            r_bone_count <= i_cfg_data;
        end
    end

    // classify the incoming transaction
    always_comb begin
        in_range    = {1'b0, i_bone_index} < 9'(MAX_BONES);
        contributes = in_range && (i_bone_index < r_bone_count) && (i_weight > 18'sd0);
        cmd.last    = i_last_influence;
        cmd.bone    = i_bone_index[BONE_W-1:0];
        cmd.elem    = i_element_index;
        cmd.value   = i_element_value;
        cmd.pos_x   = i_pos_x;
        cmd.pos_y   = i_pos_y;
        cmd.pos_z   = i_pos_z;
        cmd.weight  = i_weight;
        if (i_opcode == OP_WRITE) begin
            cmd.kind = CMD_WRITE;
            keep     = in_range;
        end else if (contributes) begin
            cmd.kind = CMD_APPLY;
            keep     = 1'b1;
        end else begin
            cmd.kind = CMD_FLUSH;
            keep     = i_last_influence;
        end
    end

    assign o_ready = (r_cnt != QCNT_W'(QUEUE_DEPTH));
    assign push    = i_valid && o_ready && keep;

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd;
        end
    end

    // queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_cmd_pop) begin
                r_rp <= (r_rp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + QCNT_W'(push) - QCNT_W'(i_cmd_pop);
        end
    end

    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];

    `VSB_ASSERT(a_queue_bound, r_cnt <= QCNT_W'(QUEUE_DEPTH), "queue count above depth")
    `VSB_ASSERT(a_pop_nonempty, i_cmd_pop |-> r_cnt != '0, "pop from empty queue")

endmodule

@@ src/vsb_back.sv @@
// back end: palette banks, row transform, weighting and blend accumulation
`include "assert_macros.svh"

module vsb_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  vsb_pkg::t_cmd      i_cmd,
    input  logic               i_cmd_valid,
    output logic               o_cmd_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [31:0] o_out_z,
    output logic signed [31:0] o_out_w
);
    import vsb_pkg::*;

    logic [1:0]         r_row;
    t_tag               r_tag1, r_tag2, r_tag3, r_tag4;
    logic signed [31:0] r_x1, r_y1, r_z1;
    logic signed [17:0] r_w1, r_w2, r_w3;
    logic signed [63:0] r_p [4];
    logic signed [31:0] r_tv;
    logic signed [49:0] r_prod;
    logic signed [31:0] r_sum [4];
    logic signed [31:0] r_out [4];
    logic               r_out_valid;

    logic [1:0]         n_row;
    t_tag               tag0;
    logic               can_emit;
    logic               we;
    logic [31:0]        rdata [4];
    logic signed [65:0] row_sum;
    logic signed [31:0] acc_new;

    assign can_emit = !(r_out_valid || r_tag1.emit || r_tag2.emit
                        || r_tag3.emit || r_tag4.emit);

    // dispatch from the queue head
    always_comb begin
        o_cmd_pop = 1'b0;
        we        = 1'b0;
        n_row     = r_row;
        tag0      = '0;
        if (i_cmd_valid) begin
            unique case (i_cmd.kind)
                CMD_WRITE: begin
                    we        = 1'b1;
                    o_cmd_pop = 1'b1;
                end
                CMD_APPLY: begin
                    if (r_row != 2'd0 || !i_cmd.last || can_emit) begin
                        tag0 = '{valid: 1'b1, row: r_row, apply: 1'b1,
                                 emit: i_cmd.last && (r_row == ROW_LAST)};
                        if (r_row == ROW_LAST) begin
                            o_cmd_pop = 1'b1;
                            n_row     = 2'd0;
                        end else begin
                            n_row = r_row + 2'd1;
                        end
                    end
                end
                CMD_FLUSH: begin
                    if (can_emit) begin
                        tag0      = '{valid: 1'b1, row: 2'd0, apply: 1'b0, emit: 1'b1};
                        o_cmd_pop = 1'b1;
                    end
                end
                default: begin
                    o_cmd_pop = 1'b1;
                end
            endcase
        end
    end

    // palette banks, one per matrix column
    for (genvar b = 0; b < 4; b++) begin : g_bank
        vsb_ram #(
            .WIDTH (32),
            .DEPTH (BANK_DEPTH)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (we && (i_cmd.elem[1:0] == 2'(b))),
            .i_waddr ({i_cmd.bone, i_cmd.elem[3:2]}),
            .i_wdata (i_cmd.value),
            .i_raddr ({i_cmd.bone, r_row}),
            .o_rdata (rdata[b])
        );
    end

    // control tags and row counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_tag1 <= '0;
            r_tag2 <= '0;
            r_tag3 <= '0;
            r_tag4 <= '0;
        end else begin
            r_row  <= n_row;
            r_tag1 <= tag0;
            r_tag2 <= r_tag1;
            r_tag3 <= r_tag2;
            r_tag4 <= r_tag3;
        end
    end

    assign row_sum = 66'(r_p[0]) + 66'(r_p[1]) + 66'(r_p[2]) + 66'(r_p[3]);

    // datapath: products, row sum, weighting
    always_ff @(posedge i_clk) begin
        r_x1   <= i_cmd.pos_x;
        r_y1   <= i_cmd.pos_y;
        r_z1   <= i_cmd.pos_z;
        r_w1   <= i_cmd.weight;
        r_p[0] <= $signed(rdata[0]) * r_x1;
        r_p[1] <= $signed(rdata[1]) * r_y1;
        r_p[2] <= $signed(rdata[2]) * r_z1;
        r_p[3] <= {{16{rdata[3][31]}}, rdata[3], 16'd0};
        r_w2   <= r_w1;
        r_tv   <= sat32(row_sum >>> 16);
        r_w3   <= r_w2;
        r_prod <= r_tv * r_w3;
    end

    assign acc_new = sat32(66'(r_sum[r_tag4.row]) + 66'(r_prod >>> 16));

    // blend sums and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_sum[k] <= '0;
            end
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_tag4.valid && r_tag4.emit) begin
                for (int k = 0; k < 4; k++) begin
                    r_out[k] <= (r_tag4.apply && r_tag4.row == 2'(k)) ? acc_new : r_sum[k];
                    r_sum[k] <= '0;
                end
                r_out_valid <= 1'b1;
            end else if (r_tag4.valid && r_tag4.apply) begin
                r_sum[r_tag4.row] <= acc_new;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_out_x = r_out[0];
    assign o_out_y = r_out[1];
    assign o_out_z = r_out[2];
    assign o_out_w = r_out[3];

    `VSB_ASSERT(a_emit_slot_free, r_tag4.valid && r_tag4.emit |-> !r_out_valid, "result overwrite")
    `VSB_ASSERT(a_one_emit, $countones({r_tag1.emit, r_tag2.emit, r_tag3.emit, r_tag4.emit}) <= 1, "two results in flight")
    `VSB_ASSERT(a_row_on_apply, r_row != 2'd0 |-> i_cmd_valid && i_cmd.kind == CMD_APPLY, "row walk lost its item")

endmodule

@@ src/vertex_skinning_blend.sv @@
// top level of the linear blend skinning block
// Linear blend skinning in Q16.16. A palette write (opcode 0) lands in one of
// four column banks. An applied influence is issued one matrix row per cycle,
// set by the three shared 32x32 multipliers and the single read port of each
// column bank; its contribution passes the bank read, product, row sum and
// weighting registers to the blend sums. A skipped influence reaches the back
// end only with the last flag. An influence with the last flag waits until the
// previous result has been taken and left the datapath. A two-entry queue sits
// between the input handshake and the datapath; the result sits in an output
// register, so input is taken while a result waits. The user writes bone_count
// through i_cfg_we/i_cfg_data only while the block is idle; the block does not
// enforce this. Palette entries read before being written are undefined.
module vertex_skinning_blend (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_opcode,
    input  logic [7:0]         i_bone_index,
    input  logic [3:0]         i_element_index,
    input  logic signed [31:0] i_element_value,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [17:0] i_weight,
    input  logic               i_last_influence,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [31:0] o_out_z,
    output logic signed [31:0] o_out_w
);
    import vsb_pkg::*;

    t_cmd cmd;
    logic cmd_valid;
    logic cmd_pop;

    // accept and classify
    vsb_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_opcode         (i_opcode),
        .i_bone_index     (i_bone_index),
        .i_element_index  (i_element_index),
        .i_element_value  (i_element_value),
        .i_pos_x          (i_pos_x),
        .i_pos_y          (i_pos_y),
        .i_pos_z          (i_pos_z),
        .i_weight         (i_weight),
        .i_last_influence (i_last_influence),
        .o_cmd            (cmd),
        .o_cmd_valid      (cmd_valid),
        .i_cmd_pop        (cmd_pop)
    );

    // transform, weight and accumulate
    vsb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y),
        .o_out_z     (o_out_z),
        .o_out_w     (o_out_w)
    );

endmodule

@@ bench/tb_top.sv @@
// self-checking testbench for the vertex skinning blend block
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import vsb_pkg::*;

    localparam int MISMATCH_SHOW = 10;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [7:0]         i_cfg_data;
    logic               i_valid;
    logic               o_ready;
    logic               i_opcode;
    logic [7:0]         i_bone_index;
    logic [3:0]         i_element_index;
    logic signed [31:0] i_element_value;
    logic signed [31:0] i_pos_x;
    logic signed [31:0] i_pos_y;
    logic signed [31:0] i_pos_z;
    logic signed [17:0] i_weight;
    logic               i_last_influence;
    logic               o_valid;
    logic               i_ready;
    logic signed [31:0] o_out_x;
    logic signed [31:0] o_out_y;
    logic signed [31:0] o_out_z;
    logic signed [31:0] o_out_w;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] w;
    } t_vertex;

    // predictor state
    logic signed [31:0] palette_model [MAX_BONES*16];
    bit                 palette_written [MAX_BONES*16];
    logic signed [63:0] sum_model [4];
    logic [7:0]         bone_count_model;
    t_vertex            expected_vertices [$];

    int  mismatch_count;
    int  vertex_count;
    int  apply_count;
    int  skip_count;
    int  hold_cycles;
    bit  run_done;

    vertex_skinning_blend u_dut (.*);

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // overall time limit
    initial begin
        #20ms;
        $display("tb_top NOT OK");
        $finish;
    end

    function automatic logic signed [63:0] floor16(input logic signed [127:0] v);
        logic signed [127:0] q;
        q = v >>> 16;
        return q[63:0];
    endfunction

    function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
        logic signed [63:0] res;
        if (v > 64'sh7FFF_FFFF) begin
            res = 64'sh7FFF_FFFF;
        end else if (v < -64'sh8000_0000) begin
            res = -64'sh8000_0000;
        end else begin
            res = v;
        end
        return res;
    endfunction

    // one transaction through the predictor
    task automatic predict_item(input logic op, input logic [7:0] bone, input logic [3:0] elem,
                                input logic signed [31:0] val, input logic signed [31:0] px,
                                input logic signed [31:0] py, input logic signed [31:0] pz,
                                input logic signed [17:0] wt, input logic last);
        logic signed [127:0] vec [4];
        logic signed [127:0] acc;
        logic signed [63:0]  row_t;
        t_vertex             v;
        if (op == OP_WRITE) begin
            if (bone < MAX_BONES) begin
                palette_model[bone*16 + elem] = val;
                palette_written[bone*16 + elem] = 1'b1;
            end
            return;
        end
        vec[0] = px;
        vec[1] = py;
        vec[2] = pz;
        vec[3] = 65536;
        if (wt > 0 && bone < bone_count_model && bone < MAX_BONES) begin
            apply_count++;
            for (int r = 0; r < 4; r++) begin
                acc = 0;
                for (int c = 0; c < 4; c++) begin
                    acc += 128'(palette_model[bone*16 + r*4 + c]) * vec[c];
                end
                row_t = clamp32(floor16(acc));
                sum_model[r] = clamp32(sum_model[r] + floor16(128'(row_t) * 128'(wt)));
            end
        end else begin
            skip_count++;
        end
        if (last) begin
            v.x = sum_model[0][31:0];
            v.y = sum_model[1][31:0];
            v.z = sum_model[2][31:0];
            v.w = sum_model[3][31:0];
            expected_vertices.push_back(v);
            for (int r = 0; r < 4; r++) sum_model[r] = 0;
        end
    endtask

    // sender: hold the transaction until accepted, then predict it
    int burst_left;
    task automatic send_item(input logic op, input logic [7:0] bone, input logic [3:0] elem,
                             input logic signed [31:0] val, input logic signed [31:0] px,
                             input logic signed [31:0] py, input logic signed [31:0] pz,
                             input logic signed [17:0] wt, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            // valid drops only for a real gap
            if (gap != 0) i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        burst_left--;
        i_valid          <= 1'b1;
        i_opcode         <= op;
        i_bone_index     <= bone;
        i_element_index  <= elem;
        i_element_value  <= val;
        i_pos_x          <= px;
        i_pos_y          <= py;
        i_pos_z          <= pz;
        i_weight         <= wt;
        i_last_influence <= last;
        do @(posedge i_clk); while (!o_ready);
        predict_item(op, bone, elem, val, px, py, pz, wt, last);
    endtask

    function automatic logic signed [17:0] rand_weight();
        logic signed [17:0] w;
        case ($urandom_range(0, 5))
            0: w = 18'sd65536;
            1: w = -18'sd65536;
            2: w = 18'sd0;
            3: w = -$signed({1'b0, 17'($urandom_range(1, 65536))});
            default: w = $signed({1'b0, 17'($urandom_range(1, 65536))});
        endcase
        return w;
    endfunction

    function automatic logic signed [31:0] rand_word();
        logic signed [31:0] v;
        case ($urandom_range(0, 4))
            0: v = 32'sh7FFF_FFFF;
            1: v = 32'sh8000_0000;
            2: v = $signed(32'($urandom_range(0, 32'h3_FFFF))) - 32'sh2_0000;
            default: v = $signed($urandom);
        endcase
        return v;
    endfunction

    // stop offering, wait for all results, then for the pipeline to drain
    task automatic drain();
        i_valid <= 1'b0;
        while (expected_vertices.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_bone_count(input logic [7:0] cnt);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= cnt;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        bone_count_model = cnt;
    endtask

    task automatic load_matrix(input logic [7:0] bone, input bit identity);
        for (int e = 0; e < 16; e++) begin
            send_item(OP_WRITE, bone, 4'(e),
                      identity ? ((e % 5 == 0) ? 32'sd65536 : 32'sd0) : rand_word(),
                      0, 0, 0, 0, 1'($urandom_range(0, 1)));
        end
    endtask

    // random bone among those fully loaded
    function automatic logic [7:0] loaded_bone();
        logic [7:0] b;
        do b = 8'($urandom_range(0, MAX_BONES - 1)); while (!palette_written[b*16]);
        return b;
    endfunction

    // directed: extremes, skip cases, ignored writes, last flag on write
    task automatic test_directed();
        write_bone_count(8'd2);
        load_matrix(8'd0, 1'b1);
        load_matrix(8'd1, 1'b0);
        load_matrix(8'd127, 1'b0);
        send_item(OP_WRITE, 8'd200, 4'd15, 32'sh7FFF_FFFF, 0, 0, 0, 0, 1'b1);
        send_item(OP_APPLY, 8'd0, 4'd0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd1,
                  18'sd65536, 1'b1);
        send_item(OP_APPLY, 8'd1, 4'd15, 0, 32'sh8000_0000, 32'sh7FFF_FFFF,
                  32'sh8000_0000, 18'sd65536, 1'b0);
        send_item(OP_APPLY, 8'd1, 4'd0, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                  32'sh7FFF_FFFF, 18'sd65536, 1'b1);
        send_item(OP_APPLY, 8'd0, 4'd0, 0, 32'sd65536, 0, 0, 18'sd0, 1'b0);
        send_item(OP_APPLY, 8'd0, 4'd0, 0, 32'sd65536, 0, 0, -18'sd65536, 1'b0);
        send_item(OP_APPLY, 8'd127, 4'd0, 0, 32'sd65536, 0, 0, 18'sd1, 1'b0);
        send_item(OP_APPLY, 8'd255, 4'd0, 0, 32'sd65536, 0, 0, 18'sd65536, 1'b1);
        write_bone_count(8'd255);
        send_item(OP_APPLY, 8'd127, 4'd0, 0, 32'sd65536, -32'sd65536, 32'sd3,
                  18'sd1, 1'b1);
        send_item(OP_APPLY, 8'd200, 4'd0, 0, 32'sd65536, 0, 0, 18'sd65536, 1'b1);
    endtask

    // random vertices of up to four influences, with writes and noise mixed in
    task automatic test_random(input int n_items, input int max_bone);
        int sent;
        int n_inf;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) == 0) begin
                load_matrix(8'($urandom_range(0, max_bone)), $urandom_range(0, 3) == 0);
                sent += 16;
            end else if ($urandom_range(0, 19) == 0) begin
                // noise: stray writes and out-of-range bones
                send_item(1'($urandom_range(0, 1)), 8'($urandom_range(MAX_BONES, 255)),
                          4'($urandom), rand_word(), rand_word(), rand_word(),
                          rand_word(), rand_weight(), 1'($urandom_range(0, 1)));
                sent++;
            end else begin
                n_inf = $urandom_range(1, 4);
                for (int k = 0; k < n_inf; k++) begin
                    send_item(OP_APPLY, loaded_bone(), 4'($urandom), rand_word(),
                              rand_word(), rand_word(), rand_word(), rand_weight(),
                              k == n_inf - 1);
                end
                sent += n_inf;
            end
        end
    endtask

    // long receiver hold-off while the sender keeps offering vertices
    task automatic test_backpressure();
        hold_cycles = 300;
        for (int k = 0; k < 12; k++) begin
            send_item(OP_APPLY, loaded_bone(), 4'd0, 0, rand_word(), rand_word(),
                      rand_word(), 18'sd40000, 1'b1);
        end
    endtask

    // receiver: stall pattern plus optional long hold-off
    initial begin
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(0, 99) < (($urandom_range(0, 7) == 0) ? 10 : 75));
            end
        end
    end

    // result checker
    initial begin
        t_vertex exp_v;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                if (expected_vertices.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MISMATCH_SHOW)
                        $display("unexpected transaction x=%h y=%h z=%h w=%h",
                                 o_out_x, o_out_y, o_out_z, o_out_w);
                end else begin
                    exp_v = expected_vertices.pop_front();
                    vertex_count++;
                    if (o_out_x !== exp_v.x || o_out_y !== exp_v.y ||
                        o_out_z !== exp_v.z || o_out_w !== exp_v.w) begin
                        mismatch_count++;
                        if (mismatch_count <= MISMATCH_SHOW)
                            $display("mismatch exp %h %h %h %h got %h %h %h %h",
                                     exp_v.x, exp_v.y, exp_v.z, exp_v.w,
                                     o_out_x, o_out_y, o_out_z, o_out_w);
                    end
                end
            end
        end
    end

    // main sequence
    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_opcode = OP_WRITE;
        i_bone_index = '0;
        i_element_index = '0;
        i_element_value = '0;
        i_pos_x = '0;
        i_pos_y = '0;
        i_pos_z = '0;
        i_weight = '0;
        i_last_influence = 1'b0;
        burst_left = 0;
        hold_cycles = 0;
        bone_count_model = '0;
        for (int r = 0; r < 4; r++) sum_model[r] = 0;
        foreach (palette_written[i]) palette_written[i] = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        write_bone_count(8'd0);
        test_random(60, 127);
        write_bone_count(8'd128);
        test_random(300, 127);
        test_backpressure();
        write_bone_count(8'd64);
        test_random(200, 127);
        write_bone_count(8'd255);
        test_random(150, 127);

        drain();
        $display("covered %0d vertices, %0d applied and %0d skipped influences,",
                 vertex_count, apply_count, skip_count);
        $display("bone counts 0, 2, 64, 128 and 255, and a long output stall");
        if (mismatch_count == 0 && expected_vertices.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
